// ===== hdl/dchs_pkg.sv =====
// dchs_pkg: shared types and constants for the density column height scan block
// no dependencies; imported by the top level, its checker and the bench

package dchs_pkg;

  localparam int DIM_DEF       = 33;
  localparam int FRAC_BITS_DEF = 12;

  localparam int DENSITY_W  = 24;
  localparam int HEIGHT_W   = 23;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int SENTINEL_INT = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_USED_SIZE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STRIDE = 1'b1;

  localparam logic [CFG_W-1:0] USED_SIZE_RST     = 6'd32;
  localparam logic [CFG_W-1:0] SAMPLE_STRIDE_RST = 6'd1;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_INCOMPLETE = 1'b1;

  typedef struct packed {
    logic                        kind;
    logic signed [DENSITY_W-1:0] density;
  } dchs_in_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic                       surface_found;
    logic                       status;
    logic                       last_column;
  } dchs_out_t;

endpackage

// ===== hdl/density_column_height_scan_top.sv =====
// density_column_height_scan_top: volume store, column scan and serial interpolation divider
// depends on dchs_pkg
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | dchs_in_t (kind, density)
//   out_    | output    | out_valid / out_ready | dchs_out_t (height, found, status, last)
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a height request on a full volume passes S_PREP, S_SCAN, S_DIV and S_HGT (these two only
// for a surface below the top sample) and S_FIN: one read of the density memory per cycle
// from the top of the column down, then one quotient bit per cycle in the restoring divider
// the result sits in an output register, so loads go on while it waits for out_ready
// reset clears fill count, column cursors and out_valid, loads cfg defaults; memory is kept

module density_column_height_scan_top
  import dchs_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dchs_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dchs_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int VOL = DIM * DIM * DIM;
  localparam int MW  = $clog2(VOL);
  localparam int CW  = $clog2(VOL + 1);
  localparam int XW  = $clog2(DIM);
  localparam int SW  = $clog2(DIM + 1);
  localparam int AW  = ((XW > CFG_W) ? XW : CFG_W) + 1;
  localparam int DW  = DENSITY_W + 1;
  localparam int KW  = $clog2(FRAC_BITS + 1);
  localparam int PW  = XW + 1 + FRAC_BITS;

  localparam logic [HEIGHT_W-1:0] TOP_H  = HEIGHT_W'((DIM - 1) * (1 << FRAC_BITS));
  localparam logic [HEIGHT_W-1:0] SENT_H = HEIGHT_W'(-SENTINEL_INT * (1 << FRAC_BITS));

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_DIV,
    S_HGT,
    S_FIN
  } state_t;

  state_t                 state_r;
  logic [DENSITY_W-1:0]   mem [VOL];
  logic [DENSITY_W-1:0]   rdata_r;
  logic [CW-1:0]          count_r;
  logic [XW-1:0]          x_cur_r;
  logic [XW-1:0]          z_cur_r;
  logic [CFG_W-1:0]       used_size_r;
  logic [CFG_W-1:0]       sample_stride_r;
  logic [MW-1:0]          addr_r;
  logic [XW-1:0]          y_r;
  logic [XW-1:0]          chk_y_r;
  logic                   chk_vld_r;
  logic                   iss_done_r;
  logic [DENSITY_W-1:0]   above_r;
  logic [XW-1:0]          hit_y_r;
  logic [DW-1:0]          rem_r;
  logic [DW-1:0]          den_r;
  logic [FRAC_BITS-1:0]   q_r;
  logic [KW-1:0]          cnt_r;
  dchs_out_t              res_r;
  logic                   out_valid_r;
  dchs_out_t              out_data_r;

  logic                   full;
  logic                   wr_en;
  logic                   rd_en;
  logic [SW-1:0]          size_w;
  logic [CFG_W-1:0]       stride_w;
  logic [XW-1:0]          x_sel;
  logic [XW-1:0]          z_sel;
  logic [AW-1:0]          x_sum;
  logic [AW-1:0]          z_sum;
  logic [MW-1:0]          base_addr;
  logic [DW:0]            r2;
  logic [DW:0]            den_ext;
  logic [PW-1:0]          top_part;
  logic [PW-1:0]          h_diff;

  assign full      = (count_r == CW'(VOL));
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign wr_en     = in_valid && in_ready && (in_data.kind == KIND_LOAD) && !full;
  assign rd_en     = (state_r == S_SCAN) && !iss_done_r;

  always_comb begin
    if (used_size_r == '0) begin
      size_w = SW'(1);
    end else if (int'(used_size_r) > DIM) begin
      size_w = SW'(DIM);
    end else begin
      size_w = SW'(used_size_r);
    end
    stride_w = (sample_stride_r == '0) ? CFG_W'(1) : sample_stride_r;
    if ((AW'(x_cur_r) >= AW'(size_w)) || (AW'(z_cur_r) >= AW'(size_w))) begin
      x_sel = '0;
      z_sel = '0;
    end else begin
      x_sel = x_cur_r;
      z_sel = z_cur_r;
    end
    x_sum     = AW'(x_sel) + AW'(stride_w);
    z_sum     = AW'(z_sel) + AW'(stride_w);
    base_addr = MW'(x_sel) + MW'(z_sel) * MW'(DIM * DIM) + MW'((DIM - 1) * DIM);
    den_ext   = {1'b0, den_r};
    r2        = {rem_r, 1'b0};
    top_part  = {(XW + 1)'(hit_y_r) + (XW + 1)'(1), {FRAC_BITS{1'b0}}};
    h_diff    = top_part - PW'(q_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[MW-1:0]] <= in_data.density;
    end
    if (rd_en) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      count_r         <= '0;
      x_cur_r         <= '0;
      z_cur_r         <= '0;
      used_size_r     <= USED_SIZE_RST;
      sample_stride_r <= SAMPLE_STRIDE_RST;
      chk_vld_r       <= 1'b0;
      iss_done_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_USED_SIZE:     used_size_r     <= cfg_data;
          REG_SAMPLE_STRIDE: sample_stride_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.kind == KIND_LOAD) begin
              if (!full) begin
                count_r <= count_r + CW'(1);
              end
            end else if (!full) begin
              count_r             <= '0;
              x_cur_r             <= '0;
              z_cur_r             <= '0;
              res_r.height        <= '0;
              res_r.surface_found <= 1'b0;
              res_r.status        <= STATUS_INCOMPLETE;
              res_r.last_column   <= 1'b1;
              state_r             <= S_FIN;
            end else begin
              state_r <= S_PREP;
            end
          end
        end

        S_PREP: begin
          addr_r       <= base_addr;
          y_r          <= XW'(DIM - 1);
          chk_vld_r    <= 1'b0;
          iss_done_r   <= 1'b0;
          res_r.status <= STATUS_OK;
          if (z_sum >= AW'(size_w)) begin
            z_cur_r <= '0;
            if (x_sum >= AW'(size_w)) begin
              x_cur_r           <= '0;
              res_r.last_column <= 1'b1;
            end else begin
              x_cur_r           <= x_sum[XW-1:0];
              res_r.last_column <= 1'b0;
            end
          end else begin
            x_cur_r           <= x_sel;
            z_cur_r           <= z_sum[XW-1:0];
            res_r.last_column <= 1'b0;
          end
          state_r <= S_SCAN;
        end

        S_SCAN: begin
          if (!iss_done_r) begin
            addr_r     <= addr_r - MW'(DIM);
            y_r        <= y_r - XW'(1);
            chk_y_r    <= y_r;
            iss_done_r <= (y_r == '0);
          end
          chk_vld_r <= !iss_done_r;
          if (chk_vld_r) begin
            if (rdata_r[DENSITY_W-1]) begin
              res_r.surface_found <= 1'b1;
              if (chk_y_r == XW'(DIM - 1)) begin
                res_r.height <= TOP_H;
                state_r      <= S_FIN;
              end else begin
                hit_y_r <= chk_y_r;
                rem_r   <= DW'(above_r);
                den_r   <= DW'(above_r) - {rdata_r[DENSITY_W-1], rdata_r};
                q_r     <= '0;
                cnt_r   <= '0;
                state_r <= S_DIV;
              end
            end else begin
              above_r <= rdata_r;
              if (chk_y_r == '0) begin
                res_r.surface_found <= 1'b0;
                res_r.height        <= SENT_H;
                state_r             <= S_FIN;
              end
            end
          end
        end

        S_DIV: begin
          if (r2 >= den_ext) begin
            rem_r <= DW'(r2 - den_ext);
            q_r   <= {q_r[FRAC_BITS-2:0], 1'b1};
          end else begin
            rem_r <= DW'(r2);
            q_r   <= {q_r[FRAC_BITS-2:0], 1'b0};
          end
          cnt_r <= cnt_r + KW'(1);
          if (cnt_r == KW'(FRAC_BITS - 1)) begin
            state_r <= S_HGT;
          end
        end

        S_HGT: begin
          res_r.height <= HEIGHT_W'(h_diff);
          state_r      <= S_FIN;
        end

        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/dchs_checker.sv =====
// dchs_checker: port-level properties of the density column height scan block
// depends on dchs_pkg; bound to density_column_height_scan_top

module dchs_checker
  import dchs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input dchs_out_t out_data
);

  localparam logic [HEIGHT_W-1:0] SENT_H = HEIGHT_W'(-SENTINEL_INT * (1 << FRAC_BITS));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_incomplete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_INCOMPLETE) |->
      out_data.last_column && !out_data.surface_found && (out_data.height == '0))
    else $error("bad incomplete result");

  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_OK) && !out_data.surface_found |->
      (out_data.height == SENT_H))
    else $error("missing sentinel height");

endmodule

bind density_column_height_scan_top dchs_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_dchs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== dv/tb_density_column_height_scan_top.sv =====
`timescale 1ns / 100ps
// tb_density_column_height_scan_top: self-checking bench for the column height scan block
// directed table then random request traffic, checked by a local predictor or a fixed want
// depends on dchs_pkg and density_column_height_scan_top

module tb_density_column_height_scan_top;
  import dchs_pkg::*;

  localparam int DIM          = DIM_DEF;
  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int VOL_SIZE     = DIM * DIM * DIM;
  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = DIM + FRAC + 5 + 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int SEGMENTS     = 20;
  localparam longint TIMEOUT_NS = 64'd60_000_000;

  localparam logic signed [HEIGHT_W-1:0] TOP_HEIGHT      = HEIGHT_W'((DIM - 1) << FRAC);
  localparam logic signed [HEIGHT_W-1:0] SENTINEL_HEIGHT = HEIGHT_W'(-(SENTINEL_INT << FRAC));
  localparam logic signed [HEIGHT_W-1:0] FLAT_HEIGHT     = HEIGHT_W'(6 << FRAC);

  localparam dchs_out_t NO_WANT         = '0;
  localparam dchs_out_t WANT_INCOMPLETE = '{23'sd0, 1'b0, STATUS_INCOMPLETE, 1'b1};
  localparam dchs_out_t WANT_TOP        = '{TOP_HEIGHT, 1'b1, STATUS_OK, 1'b0};
  localparam dchs_out_t WANT_TOP_LAST   = '{TOP_HEIGHT, 1'b1, STATUS_OK, 1'b1};
  localparam dchs_out_t WANT_NONE       = '{SENTINEL_HEIGHT, 1'b0, STATUS_OK, 1'b0};
  localparam dchs_out_t WANT_FLAT       = '{FLAT_HEIGHT, 1'b1, STATUS_OK, 1'b0};

  localparam dchs_in_t ASK      = '{KIND_REQUEST, 24'sh5a5a5a};
  localparam dchs_in_t ASK_ONES = '{KIND_REQUEST, 24'shffffff};
  localparam dchs_in_t NO_ITEM  = '0;

  typedef enum logic [1:0] {ROW_ITEM, ROW_FILL, ROW_CFG} row_op_e;

  typedef struct packed {
    row_op_e               op;
    dchs_in_t              item;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_val;
    logic                  fixed;
    dchs_out_t             want;
  } plan_row_t;

  localparam int PLAN_ROWS = 27;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b1, WANT_INCOMPLETE},
    '{ROW_ITEM, '{KIND_LOAD, 24'sh800000}, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, '{KIND_LOAD, 24'sh7fffff}, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK_ONES, REG_USED_SIZE, 6'd0, 1'b1, WANT_INCOMPLETE},
    '{ROW_FILL, NO_ITEM, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, '{KIND_LOAD, 24'shffffff}, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, '{KIND_LOAD, 24'sh800000}, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b1, WANT_TOP},
    '{ROW_ITEM, ASK_ONES, REG_USED_SIZE, 6'd0, 1'b1, WANT_NONE},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b1, WANT_FLAT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_CFG, NO_ITEM, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b1, WANT_TOP_LAST},
    '{ROW_ITEM, ASK_ONES, REG_USED_SIZE, 6'd0, 1'b1, WANT_TOP_LAST},
    '{ROW_CFG, NO_ITEM, REG_USED_SIZE, 6'd63, 1'b0, NO_WANT},
    '{ROW_CFG, NO_ITEM, REG_SAMPLE_STRIDE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_CFG, NO_ITEM, REG_SAMPLE_STRIDE, 6'd32, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT},
    '{ROW_CFG, NO_ITEM, REG_SAMPLE_STRIDE, 6'd63, 1'b0, NO_WANT},
    '{ROW_ITEM, ASK_ONES, REG_USED_SIZE, 6'd0, 1'b0, NO_WANT}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  dchs_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  dchs_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // sideband that travels with in_data: a fixed expectation for this request
  logic      fixed_want_on = 1'b0;
  dchs_out_t fixed_want = '0;

  // predictor state
  logic signed [DENSITY_W-1:0] vol_mem [VOL_SIZE];
  int unsigned      fill_count = 0;
  int unsigned      cur_x = 0;
  int unsigned      cur_z = 0;
  logic [CFG_W-1:0] size_reg = USED_SIZE_RST;
  logic [CFG_W-1:0] stride_reg = SAMPLE_STRIDE_RST;

  dchs_out_t pending_heights [$];

  int col_surface [DIM][DIM];
  bit full_rate = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned ready_hold = 0;

  int unsigned mismatch_count = 0;
  int unsigned loads_taken = 0;
  int unsigned requests_taken = 0;
  int unsigned heights_ok = 0;
  int unsigned surfaces_hit = 0;
  int unsigned incomplete_seen = 0;
  int unsigned grid_wraps = 0;
  int unsigned reg_writes = 0;

  density_column_height_scan_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned pick_gap(input bit loading);
    int unsigned r;
    if (full_rate) return 0;
    r = $urandom_range(0, 99);
    if (loading) return (r < 85) ? 0 : $urandom_range(1, 3);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DENSITY_W-1:0] random_density();
    logic [31:0] r;
    r = $urandom;
    return r[DENSITY_W-1:0];
  endfunction

  function automatic int rand_magnitude();
    case ($urandom_range(0, 15))
      0: return 0;
      1: return 8388607;
      default: return int'($urandom & ((32'd1 << $urandom_range(1, 23)) - 1));
    endcase
  endfunction

  // expected results wait here in request order
  task automatic queue_expected(input dchs_out_t res);
    pending_heights = {pending_heights, res};
  endtask

  // column scan predictor: loads fill the store, requests give one height each
  task automatic predict_height(input dchs_in_t item, output bit emits, output dchs_out_t res);
    int unsigned lim;
    int unsigned step;
    int unsigned idx;
    longint above;
    longint d;
    longint h;
    bit hit;
    res = '0;
    emits = 1'b0;
    if (item.kind == KIND_LOAD) begin
      if (fill_count < VOL_SIZE) begin
        vol_mem[fill_count] = item.density;
        fill_count++;
      end
      return;
    end
    emits = 1'b1;
    if (fill_count < VOL_SIZE) begin
      fill_count = 0;
      cur_x = 0;
      cur_z = 0;
      res = WANT_INCOMPLETE;
      return;
    end
    lim = (size_reg == 0) ? 1 : ((size_reg > DIM) ? DIM : size_reg);
    step = (stride_reg == 0) ? 1 : stride_reg;
    if (cur_x >= lim || cur_z >= lim) begin
      cur_x = 0;
      cur_z = 0;
    end
    hit = 1'b0;
    above = 0;
    h = -(longint'(SENTINEL_INT) << FRAC);
    for (int iy = DIM - 1; iy >= 0 && !hit; iy--) begin
      idx = cur_x + iy * DIM + cur_z * DIM * DIM;
      d = vol_mem[idx];
      if (d < 0) begin
        hit = 1'b1;
        if (iy == DIM - 1) h = longint'(iy) << FRAC;
        else h = (longint'(iy + 1) << FRAC) - (above << FRAC) / (above - d);
      end else begin
        above = d;
      end
    end
    res.height = h[HEIGHT_W-1:0];
    res.surface_found = hit;
    res.status = STATUS_OK;
    cur_z += step;
    if (cur_z >= lim) begin
      cur_z = 0;
      cur_x += step;
      if (cur_x >= lim) begin
        cur_x = 0;
        res.last_column = 1'b1;
      end
    end
  endtask

  // monitor: register writes, result checks, accepted loads and requests
  always @(posedge clk) begin
    bit emits;
    dchs_out_t res;
    dchs_out_t got;
    dchs_out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_USED_SIZE: size_reg = cfg_data;
          default: stride_reg = cfg_data;
        endcase
        reg_writes++;
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_heights.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected result h=%0d found=%0b status=%0b last=%0b",
                     $realtime, got.height, got.surface_found, got.status, got.last_column);
        end else begin
          want = pending_heights.pop_front();
          if (got.height !== want.height || got.surface_found !== want.surface_found ||
              got.status !== want.status || got.last_column !== want.last_column) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("[%0t] mismatch exp h=%0d f=%0b s=%0b l=%0b got h=%0d f=%0b s=%0b l=%0b",
                       $realtime, want.height, want.surface_found, want.status,
                       want.last_column, got.height, got.surface_found, got.status,
                       got.last_column);
          end
        end
        if (got.status == STATUS_INCOMPLETE) incomplete_seen++;
        else heights_ok++;
        if (got.status == STATUS_OK && got.surface_found) surfaces_hit++;
        if (got.status == STATUS_OK && got.last_column) grid_wraps++;
      end
      if (in_valid && in_ready) begin
        if (in_data.kind == KIND_LOAD) loads_taken++;
        else requests_taken++;
        predict_height(in_data, emits, res);
        if (emits) queue_expected(fixed_want_on ? fixed_want : res);
      end
    end
  end

  // result side back-pressure, including one long hold on request
  always @(posedge clk) begin
    int unsigned n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (holds_done != holds_asked) begin
      out_ready <= 1'b0;
      ready_hold <= HOLD_CYCLES - 1;
      holds_done <= holds_asked;
    end else begin
      n = pick_gap(1'b0);
      if (n == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        ready_hold <= n - 1;
      end
    end
  end

  task automatic push_item(input dchs_in_t item, input int unsigned gap, input logic fixed,
                           input dchs_out_t want);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    fixed_want_on <= fixed;
    fixed_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // broken partial loads first, the last one short by a single sample, then the full volume
  task automatic fill_volume();
    dchs_in_t item;
    int idx;
    int x;
    int y;
    int z;
    int unsigned burst;
    foreach (col_surface[i, j]) begin
      case ($urandom_range(0, 9))
        0: col_surface[i][j] = -1;
        1: col_surface[i][j] = DIM - 1;
        2: col_surface[i][j] = 0;
        default: col_surface[i][j] = $urandom_range(0, DIM - 2);
      endcase
    end
    for (int attempt = 0; attempt < 3; attempt++) begin
      burst = (attempt == 2) ? VOL_SIZE - 1 : $urandom_range(1, 400);
      item.kind = KIND_LOAD;
      repeat (burst) begin
        item.density = random_density();
        push_item(item, pick_gap(1'b1), 1'b0, NO_WANT);
      end
      item.kind = KIND_REQUEST;
      item.density = random_density();
      push_item(item, pick_gap(1'b0), 1'b1, WANT_INCOMPLETE);
    end
    item.kind = KIND_LOAD;
    for (idx = 0; idx < VOL_SIZE; idx++) begin
      x = idx % DIM;
      y = (idx / DIM) % DIM;
      z = idx / (DIM * DIM);
      if (x == 0 && z < 4) begin
        // hand-made columns: top hit, no hit, extreme interpolation, flat sample above
        case (z)
          0: item.density = (y == DIM - 1) ? -24'sd1 : 24'sd0;
          1: item.density = 24'sh7fffff;
          2: item.density = (y == 16) ? 24'sh800000 : (y == 17) ? 24'sh7fffff :
                            (y > 17) ? 24'sd0 : -24'sd5;
          default: item.density = (y == 5) ? -24'sd4096 : (y > 5) ? 24'sd0 : -24'sd1;
        endcase
      end else if (y > col_surface[x][z]) begin
        item.density = DENSITY_W'(rand_magnitude());
      end else if (y == col_surface[x][z]) begin
        item.density = DENSITY_W'(-rand_magnitude() - 1);
      end else begin
        item.density = random_density();
      end
      push_item(item, pick_gap(1'b1), 1'b0, NO_WANT);
    end
  endtask

  initial begin
    dchs_in_t item;
    logic [CFG_W-1:0] new_size;
    logic [CFG_W-1:0] new_stride;
    int unsigned batch;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      case (directed_plan[i].op)
        ROW_ITEM: push_item(directed_plan[i].item, pick_gap(1'b0), directed_plan[i].fixed,
                            directed_plan[i].want);
        ROW_FILL: fill_volume();
        default: begin
          wait_idle();
          write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
        end
      endcase
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: new_size = 6'd0;
        1: new_size = 6'd1;
        2: new_size = 6'd2;
        3: new_size = 6'd33;
        4: new_size = 6'd63;
        5: new_size = $urandom_range(34, 63);
        default: new_size = $urandom_range(1, 33);
      endcase
      case ($urandom_range(0, 9))
        0: new_stride = 6'd0;
        1: new_stride = 6'd33;
        2: new_stride = 6'd63;
        3: new_stride = $urandom_range(34, 62);
        4, 5, 6: new_stride = 6'd1;
        default: new_stride = $urandom_range(1, 8);
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_USED_SIZE, new_size);
        write_reg(REG_SAMPLE_STRIDE, new_stride);
      end else begin
        write_reg(REG_SAMPLE_STRIDE, new_stride);
        write_reg(REG_USED_SIZE, new_size);
      end
      full_rate = (seg % 6 == 5);
      if (seg == 2) holds_asked++;
      batch = $urandom_range(60, 140);
      repeat (batch) begin
        if ($urandom_range(0, 11) == 0) begin
          // samples past a full volume are dropped
          item.kind = KIND_LOAD;
          item.density = random_density();
          push_item(item, pick_gap(1'b0), 1'b0, NO_WANT);
        end
        item.kind = KIND_REQUEST;
        item.density = random_density();
        push_item(item, pick_gap(1'b0), 1'b0, NO_WANT);
      end
    end

    full_rate = 1'b0;
    wait_idle();
    $display("run: %0d loads, %0d height requests, %0d register writes",
             loads_taken, requests_taken, reg_writes);
    $display("results: %0d heights (%0d surfaces, %0d grid wraps), %0d incomplete, %0d errors",
             heights_ok, surfaces_hit, grid_wraps, incomplete_seen, mismatch_count);
    if (pending_heights.size() != 0)
      $display("%0d expected results never arrived", pending_heights.size());
    if (mismatch_count == 0 && pending_heights.size() == 0) begin
      $display("density_column_height_scan_top verification clean");
    end else begin
      $display("density_column_height_scan_top verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", pending_heights.size());
    $display("density_column_height_scan_top verification failed");
    $finish;
  end

endmodule
